// File: rtl/das_pkg.sv
// ----------------------------------------------------------------------------
// das_pkg
// Shared widths, register indexes, reset values and types of the
// differential-drive steering controller.
// ----------------------------------------------------------------------------
package das_pkg;

   localparam int POS_W       = 8;
   localparam int GAIN_W      = 16;
   localparam int ERR_W       = 9;
   localparam int SUM3_W      = 11;
   localparam int DIFF_W      = 10;
   localparam int PROD_W      = 27;
   localparam int ACC_W       = 28;
   localparam int PID_W       = ACC_W - 8;
   localparam int BIAS_W      = 14;
   localparam int MIX_W       = 22;
   localparam int SPD_W       = 11;
   localparam int DEC_W       = 8;
   localparam int DUTY_W      = 10;
   localparam int SLOPE_W     = 8;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 3;

   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int STOP_RANGE  = 5;
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;

   localparam logic [REG_IDX_W-1:0] REG_X_TARGET = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Y_TARGET = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TURN_KP  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TURN_KI  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TURN_KD  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DRIVE_KP = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DRIVE_KI = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_DRIVE_KD = 3'd7;

   localparam logic [POS_W-1:0]         X_TARGET_RST = 8'd60;
   localparam logic [POS_W-1:0]         Y_TARGET_RST = 8'd0;
   localparam logic signed [GAIN_W-1:0] TURN_KP_RST  = 16'sd1280;
   localparam logic signed [GAIN_W-1:0] DRIVE_KP_RST = 16'sd2048;
   localparam logic signed [GAIN_W-1:0] GAIN_ZERO    = 16'sd0;

   localparam logic FUNC_STEER = 1'b0;
   localparam logic FUNC_RAMP  = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0]         x_target;
      logic [POS_W-1:0]         y_target;
      logic signed [GAIN_W-1:0] turn_kp;
      logic signed [GAIN_W-1:0] turn_ki;
      logic signed [GAIN_W-1:0] turn_kd;
      logic signed [GAIN_W-1:0] drive_kp;
      logic signed [GAIN_W-1:0] drive_ki;
      logic signed [GAIN_W-1:0] drive_kd;
   } cfg_type;

   typedef struct packed {
      logic                     func;
      logic                     halted;
      logic signed [PROD_W-1:0] turn_p;
      logic signed [PROD_W-1:0] turn_i;
      logic signed [PROD_W-1:0] turn_d;
      logic signed [PROD_W-1:0] drive_p;
      logic signed [PROD_W-1:0] drive_i;
      logic signed [PROD_W-1:0] drive_d;
      logic signed [BIAS_W-1:0] bias;
      logic signed [SPD_W-1:0]  left_floor;
      logic signed [SPD_W-1:0]  right_floor;
   } work_type;

endpackage

// File: rtl/das_csr.sv
// ----------------------------------------------------------------------------
// das_csr
// APB-style configuration registers: targets and PID gains of both axes.
// ----------------------------------------------------------------------------
module das_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [das_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [das_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [das_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output das_pkg::cfg_type               cfg
);
   import das_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_X_TARGET: cfg_in.x_target = csr_pwdata[POS_W-1:0];
            REG_Y_TARGET: cfg_in.y_target = csr_pwdata[POS_W-1:0];
            REG_TURN_KP:  cfg_in.turn_kp  = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_TURN_KI:  cfg_in.turn_ki  = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_TURN_KD:  cfg_in.turn_kd  = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_DRIVE_KP: cfg_in.drive_kp = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_DRIVE_KI: cfg_in.drive_ki = $signed(csr_pwdata[GAIN_W-1:0]);
            REG_DRIVE_KD: cfg_in.drive_kd = $signed(csr_pwdata[GAIN_W-1:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_target <= X_TARGET_RST;
         cfg_ff.y_target <= Y_TARGET_RST;
         cfg_ff.turn_kp  <= TURN_KP_RST;
         cfg_ff.turn_ki  <= GAIN_ZERO;
         cfg_ff.turn_kd  <= GAIN_ZERO;
         cfg_ff.drive_kp <= DRIVE_KP_RST;
         cfg_ff.drive_ki <= GAIN_ZERO;
         cfg_ff.drive_kd <= GAIN_ZERO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_X_TARGET: csr_prdata = CSR_DATA_W'(cfg_ff.x_target);
         REG_Y_TARGET: csr_prdata = CSR_DATA_W'(cfg_ff.y_target);
         REG_TURN_KP:  csr_prdata = CSR_DATA_W'(cfg_ff.turn_kp);
         REG_TURN_KI:  csr_prdata = CSR_DATA_W'(cfg_ff.turn_ki);
         REG_TURN_KD:  csr_prdata = CSR_DATA_W'(cfg_ff.turn_kd);
         REG_DRIVE_KP: csr_prdata = CSR_DATA_W'(cfg_ff.drive_kp);
         REG_DRIVE_KI: csr_prdata = CSR_DATA_W'(cfg_ff.drive_ki);
         REG_DRIVE_KD: csr_prdata = CSR_DATA_W'(cfg_ff.drive_kd);
      endcase
   end

endmodule

// File: rtl/das_front.sv
// ----------------------------------------------------------------------------
// das_front
// Accepts items, forms the axis errors, keeps the error histories and
// computes the PID products and the slope bias.
// ----------------------------------------------------------------------------
module das_front #(
   parameter int SLOPE_GAIN = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  das_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               func,
   input  logic [das_pkg::POS_W-1:0]          x_pos,
   input  logic [das_pkg::POS_W-1:0]          y_pos,
   input  logic signed [das_pkg::SLOPE_W-1:0] slope_value,
   input  logic signed [das_pkg::SPD_W-1:0]   left_floor,
   input  logic signed [das_pkg::SPD_W-1:0]   right_floor,
   input  logic [das_pkg::QCNT_W-1:0]         q_level,
   output logic                               push,
   output das_pkg::work_type                  push_data
);
   import das_pkg::*;

   logic                      accept;
   logic                      steer;
   logic signed [ERR_W-1:0]   ex;
   logic signed [ERR_W-1:0]   ey;
   logic [QCNT_W-1:0]         in_flight;

   logic signed [ERR_W-1:0]   turn_h0_ff, turn_h1_ff, drive_h0_ff, drive_h1_ff;

   logic                      f1_valid_ff;
   logic                      f1_func_ff;
   logic                      f1_halt_ff;
   logic signed [ERR_W-1:0]   f1_ex_ff, f1_ey_ff;
   logic signed [SUM3_W-1:0]  f1_xsum_ff, f1_ysum_ff;
   logic signed [DIFF_W-1:0]  f1_xdiff_ff, f1_ydiff_ff;
   logic signed [SLOPE_W-1:0] f1_slope_ff;
   logic signed [SPD_W-1:0]   f1_lfloor_ff, f1_rfloor_ff;

   logic                      f2_valid_ff;
   work_type                  f2_work_ff;
   work_type                  f2_work_in;

   assign in_flight  = q_level + QCNT_W'(f1_valid_ff) + QCNT_W'(f2_valid_ff);
   assign req_tready = in_flight < QCNT_W'(QDEPTH);
   assign accept     = req_tvalid && req_tready;
   assign steer      = accept && (func == FUNC_STEER);

   assign ex = $signed({1'b0, x_pos}) - $signed({1'b0, cfg.x_target});
   assign ey = $signed({1'b0, y_pos}) - $signed({1'b0, cfg.y_target});

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_h0_ff  <= '0;
         turn_h1_ff  <= '0;
         drive_h0_ff <= '0;
         drive_h1_ff <= '0;
      end else if (steer) begin
         turn_h0_ff  <= ex;
         turn_h1_ff  <= turn_h0_ff;
         drive_h0_ff <= ey;
         drive_h1_ff <= drive_h0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_func_ff   <= func;
      f1_halt_ff   <= ey <= $signed(ERR_W'(STOP_RANGE));
      f1_ex_ff     <= ex;
      f1_ey_ff     <= ey;
      f1_xsum_ff   <= SUM3_W'(ex) + SUM3_W'(turn_h0_ff) + SUM3_W'(turn_h1_ff);
      f1_ysum_ff   <= SUM3_W'(ey) + SUM3_W'(drive_h0_ff) + SUM3_W'(drive_h1_ff);
      f1_xdiff_ff  <= DIFF_W'(ex) - DIFF_W'(turn_h0_ff);
      f1_ydiff_ff  <= DIFF_W'(ey) - DIFF_W'(drive_h0_ff);
      f1_slope_ff  <= slope_value;
      f1_lfloor_ff <= left_floor;
      f1_rfloor_ff <= right_floor;
   end

   always_comb begin
      f2_work_in.func        = f1_func_ff;
      f2_work_in.halted      = f1_halt_ff;
      f2_work_in.turn_p      = PROD_W'(f1_ex_ff) * PROD_W'(cfg.turn_kp);
      f2_work_in.turn_i      = PROD_W'(f1_xsum_ff) * PROD_W'(cfg.turn_ki);
      f2_work_in.turn_d      = PROD_W'(f1_xdiff_ff) * PROD_W'(cfg.turn_kd);
      f2_work_in.drive_p     = PROD_W'(f1_ey_ff) * PROD_W'(cfg.drive_kp);
      f2_work_in.drive_i     = PROD_W'(f1_ysum_ff) * PROD_W'(cfg.drive_ki);
      f2_work_in.drive_d     = PROD_W'(f1_ydiff_ff) * PROD_W'(cfg.drive_kd);
      f2_work_in.bias        = BIAS_W'(f1_slope_ff) * $signed(BIAS_W'(SLOPE_GAIN));
      f2_work_in.left_floor  = f1_lfloor_ff;
      f2_work_in.right_floor = f1_rfloor_ff;
   end

   always_ff @(posedge clock) begin
      f2_work_ff <= f2_work_in;
   end

   assign push      = f2_valid_ff;
   assign push_data = f2_work_ff;

endmodule

// File: rtl/das_queue.sv
// ----------------------------------------------------------------------------
// das_queue
// Short FIFO that decouples the front stages from the back stages.
// ----------------------------------------------------------------------------
module das_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  das_pkg::work_type          push_data,
   input  logic                       pop,
   output logic                       q_valid,
   output das_pkg::work_type          q_data,
   output logic [das_pkg::QCNT_W-1:0] q_level
);
   import das_pkg::*;

   work_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_pop;

   assign q_valid = count_ff != '0;
   assign q_data  = entry_ff[rd_ptr_ff];
   assign q_level = count_ff;
   assign do_pop  = pop && q_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
      end
   end

endmodule

// File: rtl/das_back.sv
// ----------------------------------------------------------------------------
// das_back
// Sums the PID products, mixes the motor speeds, clamps them, keeps the
// held speeds and decrements, and drives the result register.
// ----------------------------------------------------------------------------
module das_back #(
   parameter int SPEED_LIMIT = 850
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  das_pkg::work_type                 q_data,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              left_forward,
   output logic [das_pkg::DUTY_W-1:0]        left_duty,
   output logic                              right_forward,
   output logic [das_pkg::DUTY_W-1:0]        right_duty,
   output logic                              halted
);
   import das_pkg::*;

   localparam logic signed [MIX_W-1:0] LIMIT_MIX = MIX_W'(SPEED_LIMIT);

   function automatic logic signed [SPD_W-1:0] clamp_speed(input logic signed [MIX_W-1:0] v);
      logic signed [MIX_W-1:0] c;
      if (v > LIMIT_MIX) begin
         c = LIMIT_MIX;
      end else if (v < -LIMIT_MIX) begin
         c = -LIMIT_MIX;
      end else begin
         c = v;
      end
      return c[SPD_W-1:0];
   endfunction

   function automatic logic signed [DEC_W-1:0] tenth(input logic signed [SPD_W-1:0] v);
      logic [SPD_W-1:0]   mag;
      logic [SPD_W+7:0]   prod;
      logic [DEC_W-1:0]   q;
      mag  = v[SPD_W-1] ? (~v + 1'b1) : v;
      prod = (SPD_W+8)'(mag) * (SPD_W+8)'(DIV10_MUL);
      q    = prod[SPD_W+7:DIV10_SHIFT];
      return $signed(v[SPD_W-1] ? -q : q);
   endfunction

   function automatic logic signed [SPD_W-1:0] ramp_step(input logic signed [SPD_W-1:0] held,
                                                         input logic signed [DEC_W-1:0] dec,
                                                         input logic signed [SPD_W-1:0] flr);
      logic signed [MIX_W-1:0] nxt;
      logic signed [MIX_W-1:0] lim;
      nxt = MIX_W'(held) - MIX_W'(dec);
      lim = MIX_W'(flr);
      return clamp_speed((nxt >= lim) ? nxt : lim);
   endfunction

   function automatic logic [DUTY_W-1:0] duty_of(input logic signed [SPD_W-1:0] v);
      logic [SPD_W-1:0] mag;
      mag = v[SPD_W-1] ? (~v + 1'b1) : v;
      return mag[DUTY_W-1:0];
   endfunction

   logic adv;

   logic                     b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic                     b1_func_ff, b2_func_ff, b3_func_ff, b4_func_ff;
   logic                     b1_halt_ff, b2_halt_ff, b3_halt_ff, b4_halt_ff;
   logic signed [SPD_W-1:0]  b1_lflr_ff, b2_lflr_ff, b3_lflr_ff, b4_lflr_ff;
   logic signed [SPD_W-1:0]  b1_rflr_ff, b2_rflr_ff, b3_rflr_ff, b4_rflr_ff;
   logic signed [BIAS_W-1:0] b1_bias_ff, b2_bias_ff;
   logic signed [ACC_W-1:0]  b1_tacc_ff, b1_dacc_ff;
   logic signed [ACC_W-1:0]  tadj, dadj;
   logic signed [PID_W-1:0]  b2_turn_ff, b2_fwd_ff;
   logic signed [SPD_W-1:0]  b3_left_ff, b3_right_ff, b4_left_ff, b4_right_ff;
   logic signed [DEC_W-1:0]  b4_ldec_ff, b4_rdec_ff;

   logic signed [SPD_W-1:0]  lheld_ff, rheld_ff, lheld_in, rheld_in;
   logic signed [DEC_W-1:0]  ldec_ff, rdec_ff, ldec_in, rdec_in;
   logic signed [SPD_W-1:0]  lout, rout;

   logic                     rsp_valid_ff;
   logic                     lfwd_ff, rfwd_ff, halt_ff;
   logic [DUTY_W-1:0]        lduty_ff, rduty_ff;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= q_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         rsp_valid_ff <= b4_valid_ff;
      end
   end

   assign tadj = b1_tacc_ff + {{(ACC_W-8){1'b0}}, {8{b1_tacc_ff[ACC_W-1]}}};
   assign dadj = b1_dacc_ff + {{(ACC_W-8){1'b0}}, {8{b1_dacc_ff[ACC_W-1]}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_func_ff  <= q_data.func;
         b1_halt_ff  <= q_data.halted;
         b1_lflr_ff  <= q_data.left_floor;
         b1_rflr_ff  <= q_data.right_floor;
         b1_bias_ff  <= q_data.bias;
         b1_tacc_ff  <= ACC_W'(q_data.turn_p) + ACC_W'(q_data.turn_i)
                        + ACC_W'(q_data.turn_d);
         b1_dacc_ff  <= ACC_W'(q_data.drive_p) + ACC_W'(q_data.drive_i)
                        + ACC_W'(q_data.drive_d);

         b2_func_ff  <= b1_func_ff;
         b2_halt_ff  <= b1_halt_ff;
         b2_lflr_ff  <= b1_lflr_ff;
         b2_rflr_ff  <= b1_rflr_ff;
         b2_bias_ff  <= b1_bias_ff;
         b2_turn_ff  <= $signed(tadj[ACC_W-1:8]);
         b2_fwd_ff   <= $signed(dadj[ACC_W-1:8]);

         b3_func_ff  <= b2_func_ff;
         b3_halt_ff  <= b2_halt_ff;
         b3_lflr_ff  <= b2_lflr_ff;
         b3_rflr_ff  <= b2_rflr_ff;
         b3_left_ff  <= clamp_speed(MIX_W'(b2_fwd_ff) - MIX_W'(b2_turn_ff)
                                    - MIX_W'(b2_bias_ff));
         b3_right_ff <= clamp_speed(MIX_W'(b2_fwd_ff) + MIX_W'(b2_turn_ff)
                                    + MIX_W'(b2_bias_ff));

         b4_func_ff  <= b3_func_ff;
         b4_halt_ff  <= b3_halt_ff;
         b4_lflr_ff  <= b3_lflr_ff;
         b4_rflr_ff  <= b3_rflr_ff;
         b4_left_ff  <= b3_left_ff;
         b4_right_ff <= b3_right_ff;
         b4_ldec_ff  <= tenth(b3_left_ff);
         b4_rdec_ff  <= tenth(b3_right_ff);
      end
   end

   always_comb begin
      lheld_in = lheld_ff;
      rheld_in = rheld_ff;
      ldec_in  = ldec_ff;
      rdec_in  = rdec_ff;
      if (adv && b4_valid_ff) begin
         if (b4_func_ff == FUNC_RAMP) begin
            lheld_in = ramp_step(lheld_ff, ldec_ff, b4_lflr_ff);
            rheld_in = ramp_step(rheld_ff, rdec_ff, b4_rflr_ff);
         end else if (!b4_halt_ff) begin
            lheld_in = b4_left_ff;
            rheld_in = b4_right_ff;
            ldec_in  = b4_ldec_ff;
            rdec_in  = b4_rdec_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lheld_ff <= '0;
         rheld_ff <= '0;
         ldec_ff  <= '0;
         rdec_ff  <= '0;
      end else begin
         lheld_ff <= lheld_in;
         rheld_ff <= rheld_in;
         ldec_ff  <= ldec_in;
         rdec_ff  <= rdec_in;
      end
   end

   assign lout = (b4_func_ff == FUNC_STEER && b4_halt_ff) ? '0 : lheld_in;
   assign rout = (b4_func_ff == FUNC_STEER && b4_halt_ff) ? '0 : rheld_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         lfwd_ff  <= !lout[SPD_W-1] && (lout != '0);
         rfwd_ff  <= !rout[SPD_W-1] && (rout != '0);
         lduty_ff <= duty_of(lout);
         rduty_ff <= duty_of(rout);
         halt_ff  <= (b4_func_ff == FUNC_STEER) && b4_halt_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign left_forward  = lfwd_ff;
   assign left_duty     = lduty_ff;
   assign right_forward = rfwd_ff;
   assign right_duty    = rduty_ff;
   assign halted        = halt_ff;

endmodule

// File: rtl/dual_axis_approach_steering.sv
// ----------------------------------------------------------------------------
// dual_axis_approach_steering
// Differential-drive steering controller with two PID axes and ramp-down.
// ----------------------------------------------------------------------------
// An item passes stages f1 and f2, the queue, stages b1 to b4 and the result register.
// Throughput: one item per cycle while the result channel is not stalled and the front has room.
// The front accepts while its stages and the four-entry queue have room.
// Reset clears the histories, held speeds, decrements, queue and valid bits
// and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_axis_approach_steering #(
   parameter int SPEED_LIMIT = 850,
   parameter int SLOPE_GAIN  = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // x_pos[7:0], y_pos[15:8], slope_value[23:16], left_floor[34:24],
   // right_floor[45:35], zero[47:46]
   input  logic [das_pkg::REQ_DATA_W-1:0] req_tdata,
   // func[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // left_forward[0], left_duty[10:1], right_forward[11], right_duty[21:12],
   // zero[23:22]
   output logic [das_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // halted[0]
   output logic                           rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [das_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [das_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [das_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import das_pkg::*;

   cfg_type            cfg;
   logic               push, pop, q_valid;
   work_type           push_data, q_data;
   logic [QCNT_W-1:0]  q_level;
   logic               left_forward, right_forward, halted;
   logic [DUTY_W-1:0]  left_duty, right_duty;

   das_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   das_front #(
      .SLOPE_GAIN (SLOPE_GAIN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .func        (req_tuser),
      .x_pos       (req_tdata[7:0]),
      .y_pos       (req_tdata[15:8]),
      .slope_value ($signed(req_tdata[23:16])),
      .left_floor  ($signed(req_tdata[34:24])),
      .right_floor ($signed(req_tdata[45:35])),
      .q_level     (q_level),
      .push        (push),
      .push_data   (push_data)
   );

   das_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_level   (q_level)
   );

   das_back #(
      .SPEED_LIMIT (SPEED_LIMIT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .left_forward  (left_forward),
      .left_duty     (left_duty),
      .right_forward (right_forward),
      .right_duty    (right_duty),
      .halted        (halted)
   );

   assign rsp_tdata = {2'b00, right_duty, right_forward, left_duty, left_forward};
   assign rsp_tuser = halted;

endmodule

// File: rtl/das_checker.sv
// ----------------------------------------------------------------------------
// das_checker
// Port-level checks of the steering controller's result channel.
// ----------------------------------------------------------------------------
module das_checker #(
   parameter int SPEED_LIMIT = 850
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [das_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser
);
   import das_pkg::*;

   localparam logic [DUTY_W-1:0] LIMIT_DUTY = DUTY_W'(SPEED_LIMIT);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[21:0] == 22'd0)
      else $error("halted result drives the motors");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:1] <= LIMIT_DUTY && rsp_tdata[21:12] <= LIMIT_DUTY)
      else $error("duty beyond the speed limit");

   a_forward_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[10:1] != '0)
                     && (!rsp_tdata[11] || rsp_tdata[21:12] != '0))
      else $error("forward direction with zero duty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind dual_axis_approach_steering das_checker #(
   .SPEED_LIMIT (SPEED_LIMIT)
) u_das_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Steering controller testbench
// Drives steer and ramp items into the controller through the request stream.
// It predicts each result from its own model of the two PID axes, the speed
// clamps and the ramp-down state, and checks every result field by field.
// The registers are set through the APB port to several settings, the
// extremes among them, and are read back. Both streams idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import das_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 12;
   localparam int SPEED_MAX    = 850;
   localparam int SLOPE_MUL    = 10;
   localparam int DEC_DIVISOR  = 10;
   localparam int PHASE_ITEMS  = 75;
   localparam int PHASE_COUNT  = 8;

   typedef struct {
      bit       left_fwd;
      bit [9:0] left_duty;
      bit       right_fwd;
      bit [9:0] right_duty;
      bit       halted;
   } wheel_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = FUNC_STEER;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type cfg = '{x_target: X_TARGET_RST, y_target: Y_TARGET_RST,
                    turn_kp: TURN_KP_RST, turn_ki: GAIN_ZERO, turn_kd: GAIN_ZERO,
                    drive_kp: DRIVE_KP_RST, drive_ki: GAIN_ZERO, drive_kd: GAIN_ZERO};

   longint turn_hist[2]  = '{0, 0};
   longint drive_hist[2] = '{0, 0};
   longint left_held  = 0;
   longint right_held = 0;
   longint left_dec   = 0;
   longint right_dec  = 0;

   wheel_cmd_type wheel_queue[$];
   bit no_gaps = 1'b0;
   int mismatches = 0;
   int n_steer = 0;
   int n_ramp = 0;
   int n_halt = 0;
   int n_settings = 0;

   dual_axis_approach_steering dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint clamp_speed(longint v);
      if (v < -SPEED_MAX) return -SPEED_MAX;
      if (v > SPEED_MAX) return SPEED_MAX;
      return v;
   endfunction

   function automatic longint pid_sum(longint e, longint e1, longint e2,
                                      longint kp, longint ki, longint kd);
      return (kp * e + ki * (e + e1 + e2) + kd * (e - e1)) / 256;
   endfunction

   function automatic longint ramp_speed(longint held, longint dec, longint floor_val);
      longint next_val;
      next_val = held - dec;
      return clamp_speed(next_val >= floor_val ? next_val : floor_val);
   endfunction

   function automatic wheel_cmd_type wheel_cmd(longint l, longint r, bit halt);
      wheel_cmd_type c;
      c.left_fwd   = l > 0;
      c.left_duty  = 10'(l < 0 ? -l : l);
      c.right_fwd  = r > 0;
      c.right_duty = 10'(r < 0 ? -r : r);
      c.halted     = halt;
      return c;
   endfunction

   function automatic wheel_cmd_type predict_wheels(bit ramp_step, bit [7:0] x, bit [7:0] y,
                                                    bit signed [7:0] slope,
                                                    bit signed [10:0] lfloor,
                                                    bit signed [10:0] rfloor);
      longint ex, ey, turn, fwd, bias, l, r;
      if (ramp_step) begin
         left_held  = ramp_speed(left_held, left_dec, longint'(lfloor));
         right_held = ramp_speed(right_held, right_dec, longint'(rfloor));
         return wheel_cmd(left_held, right_held, 1'b0);
      end
      ex = longint'(x) - longint'(cfg.x_target);
      ey = longint'(y) - longint'(cfg.y_target);
      turn = pid_sum(ex, turn_hist[0], turn_hist[1], $signed(cfg.turn_kp),
                     $signed(cfg.turn_ki), $signed(cfg.turn_kd));
      fwd = pid_sum(ey, drive_hist[0], drive_hist[1], $signed(cfg.drive_kp),
                    $signed(cfg.drive_ki), $signed(cfg.drive_kd));
      turn_hist[1]  = turn_hist[0];
      turn_hist[0]  = ex;
      drive_hist[1] = drive_hist[0];
      drive_hist[0] = ey;
      if (ey <= STOP_RANGE) return wheel_cmd(0, 0, 1'b1);
      bias = longint'(slope) * SLOPE_MUL;
      l = clamp_speed(fwd - turn - bias);
      r = clamp_speed(fwd + turn + bias);
      left_held  = l;
      right_held = r;
      left_dec   = l / DEC_DIVISOR;
      right_dec  = r / DEC_DIVISOR;
      return wheel_cmd(l, r, 1'b0);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at %0d ns: %s got %0d expected %0d", $time, what, got, want);
   endtask

   task automatic send_item(bit ramp_step, bit [7:0] x, bit [7:0] y, bit signed [7:0] slope,
                            bit signed [10:0] lfloor, bit signed [10:0] rfloor);
      int gap;
      wheel_cmd_type c;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ramp_step ? FUNC_RAMP : FUNC_STEER;
      req_tdata  <= {2'b00, rfloor, lfloor, slope, y, x};
      do @(posedge clock); while (!req_tready);
      c = predict_wheels(ramp_step, x, y, slope, lfloor, rfloor);
      wheel_queue.push_back(c);
      if (ramp_step) n_ramp++;
      else n_steer++;
      if (c.halted) n_halt++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (wheel_queue.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_X_TARGET: cfg.x_target = value[7:0];
         REG_Y_TARGET: cfg.y_target = value[7:0];
         REG_TURN_KP:  cfg.turn_kp  = value[15:0];
         REG_TURN_KI:  cfg.turn_ki  = value[15:0];
         REG_TURN_KD:  cfg.turn_kd  = value[15:0];
         REG_DRIVE_KP: cfg.drive_kp = value[15:0];
         REG_DRIVE_KI: cfg.drive_ki = value[15:0];
         REG_DRIVE_KD: cfg.drive_kd = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_readback(logic [REG_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] got;
      logic [15:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_X_TARGET: want = {8'h00, cfg.x_target};
         REG_Y_TARGET: want = {8'h00, cfg.y_target};
         REG_TURN_KP:  want = cfg.turn_kp;
         REG_TURN_KI:  want = cfg.turn_ki;
         REG_TURN_KD:  want = cfg.turn_kd;
         REG_DRIVE_KP: want = cfg.drive_kp;
         REG_DRIVE_KI: want = cfg.drive_ki;
         default:      want = cfg.drive_kd;
      endcase
      if (idx == REG_X_TARGET || idx == REG_Y_TARGET) begin
         if (got[7:0] !== want[7:0]) report_mismatch("register readback", got[7:0], want[7:0]);
      end else if (got[15:0] !== want) begin
         report_mismatch("register readback", got[15:0], want);
      end
      @(posedge clock);
   endtask

   task automatic apply_setting(bit [7:0] x_t, bit [7:0] y_t,
                                bit [15:0] tkp, bit [15:0] tki, bit [15:0] tkd,
                                bit [15:0] dkp, bit [15:0] dki, bit [15:0] dkd);
      wait_drained();
      csr_write(REG_X_TARGET, {24'h0, x_t});
      csr_write(REG_Y_TARGET, {24'h0, y_t});
      csr_write(REG_TURN_KP, {16'h0, tkp});
      csr_write(REG_TURN_KI, {16'h0, tki});
      csr_write(REG_TURN_KD, {16'h0, tkd});
      csr_write(REG_DRIVE_KP, {16'h0, dkp});
      csr_write(REG_DRIVE_KI, {16'h0, dki});
      csr_write(REG_DRIVE_KD, {16'h0, dkd});
      n_settings++;
   endtask

   function automatic bit [7:0] pick_coord(int center, int span);
      int v;
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
      v = center + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic bit [10:0] pick_floor();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return 11'(int'($urandom_range(0, 2 * SPEED_MAX)) - SPEED_MAX);
      if (k < 8) return 11'(0);
      return 11'($urandom_range(0, 2047));
   endfunction

   function automatic bit [15:0] pick_gain(int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic test_register_access();
      for (int i = 0; i < 8; i++) check_readback(REG_IDX_W'(i));
      for (int i = 0; i < 8; i++) begin
         csr_write(REG_IDX_W'(i), {16'($urandom_range(0, 65535)), 16'h7FFF} | 32'h0000_00FF);
         check_readback(REG_IDX_W'(i));
         csr_write(REG_IDX_W'(i), {16'($urandom_range(0, 65535)), 16'h8000});
         check_readback(REG_IDX_W'(i));
      end
      apply_setting(X_TARGET_RST, Y_TARGET_RST, TURN_KP_RST, GAIN_ZERO, GAIN_ZERO,
                    DRIVE_KP_RST, GAIN_ZERO, GAIN_ZERO);
      for (int i = 0; i < 8; i++) check_readback(REG_IDX_W'(i));
   endtask

   task automatic test_close_range();
      send_item(1'b0, 8'd60, 8'd0, 8'sd0, 11'sd0, 11'sd0);
      send_item(1'b0, 8'd60, 8'd5, 8'sd0, 11'sd0, 11'sd0);
      send_item(1'b0, 8'd60, 8'd6, 8'sd0, 11'sd0, 11'sd0);
      send_item(1'b0, 8'd90, 8'd200, 8'sd5, 11'sd0, 11'sd0);
      send_item(1'b0, 8'd20, 8'd3, -8'sd7, -11'sd300, 11'sd300);
   endtask

   task automatic test_field_extremes();
      send_item(1'b0, 8'd0, 8'd255, 8'sd127, 11'sd0, 11'sd0);
      send_item(1'b0, 8'd255, 8'd255, -8'sd128, 11'sd0, 11'sd0);
      repeat (3) send_item(1'b1, 8'd0, 8'd0, 8'sd0, 11'sd0, 11'sd0);
      send_item(1'b1, 8'd255, 8'd255, -8'sd1, -11'sd1024, 11'sd1023);
      send_item(1'b1, 8'd0, 8'd0, 8'sd0, -11'sd850, 11'sd850);
      send_item(1'b0, 8'd120, 8'd180, 8'sd0, 11'sd0, 11'sd0);
      send_item(1'b1, 8'd0, 8'd0, 8'sd0, 11'sd850, 11'sd851);
      // A negative held speed ramps upward while the floor stays below it.
      send_item(1'b0, 8'd255, 8'd40, 8'sd127, 11'sd0, 11'sd0);
      repeat (3) send_item(1'b1, 8'd0, 8'd0, 8'sd0, -11'sd1024, 11'sd0);
      send_item(1'b1, 8'd0, 8'd0, 8'sd0, 11'sd1023, -11'sd1024);
   endtask

   task automatic send_random_stream(int n_items);
      int sent;
      int steers;
      int ramps;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                      11'($urandom), 11'($urandom));
            sent++;
         end else begin
            steers = $urandom_range(1, 3);
            ramps  = $urandom_range(0, 6);
            repeat (steers) begin
               send_item(1'b0, pick_coord(cfg.x_target, 40),
                         pick_coord(int'(cfg.y_target) + STOP_RANGE, 12),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6) - 3)
                                                     : 8'($urandom),
                         11'($urandom), 11'($urandom));
            end
            repeat (ramps) begin
               send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                         pick_floor(), pick_floor());
            end
            sent += steers + ramps;
         end
      end
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: apply_setting(8'd0, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF, 16'h7FFF);
            1: apply_setting(8'd255, 8'd0, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000);
            2: apply_setting(8'd128, 8'd255, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO,
                             GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
            3: apply_setting(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            default: apply_setting(8'($urandom), 8'($urandom_range(0, 120)),
                                   pick_gain(3000), pick_gain(800), pick_gain(800),
                                   pick_gain(3000), pick_gain(800), pick_gain(800));
         endcase
         send_random_stream(PHASE_ITEMS);
      end
      no_gaps = 1'b0;
   endtask

   initial begin : result_check
      int stall;
      wheel_cmd_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         if (wheel_queue.size() == 0) begin
            report_mismatch("result with nothing pending, tdata", rsp_tdata, 0);
         end else begin
            want = wheel_queue.pop_front();
            if (rsp_tdata[0] !== want.left_fwd)
               report_mismatch("left_forward", rsp_tdata[0], want.left_fwd);
            if (rsp_tdata[10:1] !== want.left_duty)
               report_mismatch("left_duty", rsp_tdata[10:1], want.left_duty);
            if (rsp_tdata[11] !== want.right_fwd)
               report_mismatch("right_forward", rsp_tdata[11], want.right_fwd);
            if (rsp_tdata[21:12] !== want.right_duty)
               report_mismatch("right_duty", rsp_tdata[21:12], want.right_duty);
            if (rsp_tuser !== want.halted)
               report_mismatch("halted", rsp_tuser, want.halted);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, wheel_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_close_range();
      test_field_extremes();
      test_random_phases();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d steer and %0d ramp items; %0d steer items stopped the motors.",
               n_steer, n_ramp, n_halt);
      $display("Used %0d register settings; %0d mismatches found.", n_settings, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
